FILE: design/wdc_pkg.sv
package wdc_pkg;

  // Field and register widths
  localparam int WeightBits  = 16;
  localparam int TargetBits  = 16;
  localparam int DelivBits   = 16;
  localparam int CountBits   = 16;
  localparam int TolBits     = 8;
  localparam int TimeoutBits = 10;
  localparam int CmdBits     = 2;
  localparam int StatusBits  = 3;

  // Configuration port
  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = (TolBits > TimeoutBits) ? TolBits : TimeoutBits;

  localparam logic [CfgIdxBits-1:0] CFG_TOLERANCE = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CFG_TIMEOUT   = CfgIdxBits'(1);

  localparam logic [TolBits-1:0]     TolReset     = TolBits'(2);
  localparam logic [TimeoutBits-1:0] TimeoutReset = TimeoutBits'(50);

  // Drop from baseline is held wide enough for both weight and delivered width;
  // the reach compare adds a sign bit and headroom for target minus tolerance
  localparam int DropBits = (WeightBits > DelivBits) ? WeightBits : DelivBits;
  localparam int CmpBits  = DropBits + 2;

  // Front-to-back queue
  localparam int QueueDepth = 2;
  localparam int PtrBits    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int FillBits   = $clog2(QueueDepth + 1);

  typedef enum logic [CmdBits-1:0] {
    CMD_START  = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [StatusBits-1:0] {
    ST_IDLE       = 3'd0,
    ST_FEEDING    = 3'd1,
    ST_SETTLING   = 3'd2,
    ST_DONE       = 3'd3,
    ST_BLOCKED    = 3'd4,
    ST_BADTARGET  = 3'd5,
    ST_SENSORFAIL = 3'd6,
    ST_BUSY       = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_FEED   = 3'b010,
    PH_SETTLE = 3'b100
  } phase_t;

  // Classified item carried from front to back
  typedef struct packed {
    cmd_t                   cmd;
    logic                   target_ok;
    logic [TargetBits-1:0]  target;
    logic [WeightBits-1:0]  weight;
    logic                   weight_valid;
  } item_t;

endpackage

FILE: design/wdc_front.sv
module wdc_front (
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [wdc_pkg::CmdBits-1:0]          command,
  input  logic signed [wdc_pkg::TargetBits-1:0] target_grams,
  input  logic [wdc_pkg::WeightBits-1:0]       weight_grams,
  input  logic                                 weight_valid,
  input  logic                                 q_full,
  output logic                                 q_push,
  output wdc_pkg::item_t                       q_item
);

  // Accept whenever the queue has room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Decode the command and check the target for a positive value
  always_comb begin
    q_item.cmd          = wdc_pkg::cmd_t'(command);
    q_item.target_ok    = !target_grams[wdc_pkg::TargetBits-1] && (target_grams != '0);
    q_item.target       = target_grams;
    q_item.weight       = weight_grams;
    q_item.weight_valid = weight_valid;
  end

endmodule

FILE: design/wdc_queue.sv
module wdc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wdc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output wdc_pkg::item_t head_item
);

  wdc_pkg::item_t                  entries [wdc_pkg::QueueDepth];
  logic [wdc_pkg::PtrBits-1:0]     wr_ptr;
  logic [wdc_pkg::PtrBits-1:0]     rd_ptr;
  logic [wdc_pkg::FillBits-1:0]    fill;

  assign full       = (fill == wdc_pkg::FillBits'(wdc_pkg::QueueDepth));
  assign head_valid = (fill != '0);
  assign head_item  = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == wdc_pkg::PtrBits'(wdc_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == wdc_pkg::PtrBits'(wdc_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: design/wdc_back.sv
module wdc_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [wdc_pkg::CfgIdxBits-1:0]      cfg_index,
  input  logic [wdc_pkg::CfgDataBits-1:0]     cfg_data,
  input  logic                                head_valid,
  input  wdc_pkg::item_t                      head_item,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                motor_on,
  output logic [wdc_pkg::StatusBits-1:0]      status,
  output logic [wdc_pkg::DelivBits-1:0]       delivered_grams,
  output logic [wdc_pkg::CountBits-1:0]       feed_total,
  output logic [wdc_pkg::CountBits-1:0]       block_total,
  output logic                                blocked_flag
);

  localparam int DB = wdc_pkg::DropBits;
  localparam int CB = wdc_pkg::CmpBits;

  // Configuration
  logic [wdc_pkg::TolBits-1:0]     tolerance;
  logic [wdc_pkg::TimeoutBits-1:0] timeout;

  // Feed state
  wdc_pkg::phase_t                 phase, phase_next;
  logic [wdc_pkg::WeightBits-1:0]  baseline, baseline_next;
  logic [wdc_pkg::TargetBits-1:0]  target_amt, target_amt_next;
  logic [wdc_pkg::TimeoutBits-1:0] intervals, intervals_next;
  logic [wdc_pkg::DelivBits-1:0]   last_deliv, last_deliv_next;
  logic [wdc_pkg::CountBits-1:0]   feeds, feeds_next;
  logic [wdc_pkg::CountBits-1:0]   blocks, blocks_next;
  logic                            block_mark, block_mark_next;
  wdc_pkg::status_t                st;

  // Datapath
  logic [wdc_pkg::WeightBits-1:0]  drop;
  logic [DB-1:0]                   drop_ext;
  logic [wdc_pkg::DelivBits-1:0]   drop_sat;
  logic signed [CB-1:0]            need;
  logic                            reached;

  assign pop = head_valid && (!out_valid || !out_stall);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= wdc_pkg::TolReset;
      timeout   <= wdc_pkg::TimeoutReset;
    end else if (cfg_write) begin
      case (cfg_index)
        wdc_pkg::CFG_TOLERANCE: tolerance <= cfg_data[wdc_pkg::TolBits-1:0];
        wdc_pkg::CFG_TIMEOUT:   timeout   <= cfg_data[wdc_pkg::TimeoutBits-1:0];
        default: ;
      endcase
    end
  end

  // Drop from baseline, clamped at zero, and the reach check
  always_comb begin
    drop     = (baseline > head_item.weight) ? baseline - head_item.weight : '0;
    drop_ext = DB'(drop);
    drop_sat = (drop_ext > DB'({wdc_pkg::DelivBits{1'b1}})) ?
               {wdc_pkg::DelivBits{1'b1}} : drop_ext[wdc_pkg::DelivBits-1:0];
    need     = $signed({{(CB - wdc_pkg::TargetBits){1'b0}}, target_amt})
             - $signed({{(CB - wdc_pkg::TolBits){1'b0}}, tolerance});
    reached  = $signed({2'b00, drop_ext}) >= need;
  end

  // Per-command state update
  always_comb begin
    phase_next      = phase;
    baseline_next   = baseline;
    target_amt_next = target_amt;
    intervals_next  = intervals;
    last_deliv_next = last_deliv;
    feeds_next      = feeds;
    blocks_next     = blocks;
    block_mark_next = block_mark;
    st              = wdc_pkg::ST_IDLE;
    case (head_item.cmd)
      wdc_pkg::CMD_START: begin
        if (phase != wdc_pkg::PH_IDLE) begin
          st = wdc_pkg::ST_BUSY;
        end else if (!head_item.target_ok) begin
          st = wdc_pkg::ST_BADTARGET;
        end else if (!head_item.weight_valid) begin
          st = wdc_pkg::ST_SENSORFAIL;
        end else begin
          baseline_next   = head_item.weight;
          target_amt_next = head_item.target;
          intervals_next  = '0;
          block_mark_next = 1'b0;
          phase_next      = wdc_pkg::PH_FEED;
          st              = wdc_pkg::ST_FEEDING;
        end
      end
      wdc_pkg::CMD_SAMPLE: begin
        case (phase)
          wdc_pkg::PH_FEED: begin
            if (intervals >= timeout) begin
              phase_next      = wdc_pkg::PH_IDLE;
              block_mark_next = 1'b1;
              blocks_next     = blocks + 1'b1;
              st              = wdc_pkg::ST_BLOCKED;
            end else begin
              intervals_next = intervals + 1'b1;
              st             = wdc_pkg::ST_FEEDING;
              if (head_item.weight_valid && reached) begin
                phase_next = wdc_pkg::PH_SETTLE;
                st         = wdc_pkg::ST_SETTLING;
              end
            end
          end
          wdc_pkg::PH_SETTLE: begin
            if (!head_item.weight_valid) begin
              st = wdc_pkg::ST_SENSORFAIL;
            end else begin
              last_deliv_next = drop_sat;
              feeds_next      = feeds + 1'b1;
              phase_next      = wdc_pkg::PH_IDLE;
              st              = wdc_pkg::ST_DONE;
            end
          end
          default: st = wdc_pkg::ST_IDLE;
        endcase
      end
      wdc_pkg::CMD_STOP: begin
        phase_next = wdc_pkg::PH_IDLE;
        st         = wdc_pkg::ST_BUSY;
      end
      default: begin
        case (phase)
          wdc_pkg::PH_FEED:   st = wdc_pkg::ST_FEEDING;
          wdc_pkg::PH_SETTLE: st = wdc_pkg::ST_SETTLING;
          default:            st = wdc_pkg::ST_IDLE;
        endcase
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= wdc_pkg::PH_IDLE;
      baseline   <= '0;
      target_amt <= '0;
      intervals  <= '0;
      last_deliv <= '0;
      feeds      <= '0;
      blocks     <= '0;
      block_mark <= 1'b0;
    end else if (pop) begin
      phase      <= phase_next;
      baseline   <= baseline_next;
      target_amt <= target_amt_next;
      intervals  <= intervals_next;
      last_deliv <= last_deliv_next;
      feeds      <= feeds_next;
      blocks     <= blocks_next;
      block_mark <= block_mark_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      motor_on        <= (phase_next == wdc_pkg::PH_FEED);
      status          <= st;
      delivered_grams <= last_deliv_next;
      feed_total      <= feeds_next;
      block_total     <= blocks_next;
      blocked_flag    <= block_mark_next;
    end
  end

endmodule

FILE: design/weighed_dispense_controller.sv
// Weighed dispense controller.
// Input channel (in_valid / in_stall): one transaction per command: start feed
// with target and baseline weight, weight sample for one check interval, stop,
// or query. Output channel (out_valid / out_stall): exactly one result per
// command, in order: motor enable, status code, last delivered grams, feed and
// timeout counters, and the blocked flag.
// Configuration (cfg_write / cfg_index / cfg_data): index 0 tolerance grams,
// index 1 timeout in check intervals; write only while no command is in flight.
// A command accepted on the input is queued, then popped by the back stage into
// the result register. Throughput: one command per cycle while out_stall is low;
// each command is a combinational compare-and-update of the back-stage feed state.
// A two-entry queue sits between the command decoder and the back stage; when
// the receiver holds out_stall, the result register holds, the queue fills and
// in_stall rises once two commands wait.
// Reset (rst, synchronous): feed state idle, counters and delivered grams zero,
// tolerance 2, timeout 50, queue empty, no result pending.
module weighed_dispense_controller (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [wdc_pkg::CfgIdxBits-1:0]        cfg_index,
  input  logic [wdc_pkg::CfgDataBits-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [wdc_pkg::CmdBits-1:0]           command,
  input  logic signed [wdc_pkg::TargetBits-1:0] target_grams,
  input  logic [wdc_pkg::WeightBits-1:0]        weight_grams,
  input  logic                                  weight_valid,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  motor_on,
  output logic [wdc_pkg::StatusBits-1:0]        status,
  output logic [wdc_pkg::DelivBits-1:0]         delivered_grams,
  output logic [wdc_pkg::CountBits-1:0]         feed_total,
  output logic [wdc_pkg::CountBits-1:0]         block_total,
  output logic                                  blocked_flag
);

  logic           q_full;
  logic           q_push;
  wdc_pkg::item_t q_item;
  logic           q_pop;
  logic           head_valid;
  wdc_pkg::item_t head_item;

  wdc_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .target_grams (target_grams),
    .weight_grams (weight_grams),
    .weight_valid (weight_valid),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_item)
  );

  wdc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  wdc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .head_valid      (head_valid),
    .head_item       (head_item),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .motor_on        (motor_on),
    .status          (status),
    .delivered_grams (delivered_grams),
    .feed_total      (feed_total),
    .block_total     (block_total),
    .blocked_flag    (blocked_flag)
  );

endmodule

FILE: design/wdc_checker.sv
module wdc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             motor_on,
  input logic [wdc_pkg::StatusBits-1:0]   status,
  input logic [wdc_pkg::CountBits-1:0]    feed_total,
  input logic                             blocked_flag
);

  // A stalled result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(feed_total))
    else $error("stalled result changed");

  // Motor runs only when the feed is still in progress
  a_motor_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && motor_on |->
      (status == wdc_pkg::ST_FEEDING) || (status == wdc_pkg::ST_BUSY))
    else $error("motor on with a status that ends the feed");

  // A timeout stops the motor and raises the blocked flag
  a_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == wdc_pkg::ST_BLOCKED) |-> blocked_flag && !motor_on)
    else $error("blocked result without flag or with motor on");

  // Reset leaves no result pending
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind weighed_dispense_controller wdc_checker u_wdc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .motor_on     (motor_on),
  .status       (status),
  .feed_total   (feed_total),
  .blocked_flag (blocked_flag)
);
